>>> rtl/ssg_pkg.sv
// Shared types, codes and constants of the spindle-synchronised step generator.
// No dependencies; every other file of the block imports this package.
package ssg_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 31;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned AccW     = 17;
  localparam int unsigned PosW     = 32;
  localparam int unsigned DroW     = 24;

  typedef enum logic [1:0] {
    KIND_EDGE = 2'd0,
    KIND_ARM  = 2'd1,
    KIND_EXIT = 2'd2,
    KIND_POLL = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    RUN_IDLE   = 4'b0001,
    RUN_PAUSED = 4'b0010,
    RUN_ACTIVE = 4'b0100,
    RUN_LIMIT  = 4'b1000
  } run_state_e;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_PAUSED = 2'd1;
  localparam logic [1:0] MODE_ACTIVE = 2'd2;
  localparam logic [1:0] MODE_LIMIT  = 2'd3;

  localparam logic [1:0] SDIR_UNKNOWN = 2'd0;
  localparam logic [1:0] SDIR_CW      = 2'd1;
  localparam logic [1:0] SDIR_CCW     = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_NUMERATOR    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DENOMINATOR  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_REVERSE      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CLOSED_LOOP  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_STEP_SIZE    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_LENGTH_LIMIT = 3'd5;

  localparam logic [15:0] RST_NUMERATOR    = 16'd1;
  localparam logic [15:0] RST_DENOMINATOR  = 16'd1;
  localparam logic [15:0] RST_STEP_SIZE    = 16'd66;
  localparam logic [30:0] RST_LENGTH_LIMIT = 31'd655360;

  // Home band of 0.01 mm in Q16.16.
  localparam logic signed [PosW-1:0] HOME_BAND = 32'sd655;

  // Reciprocals of 125: ceil(2^30/125) and ceil(2^27/125).
  localparam logic [23:0] DIV125_M1 = 24'd8589935;
  localparam logic [20:0] DIV125_M2 = 21'd1073742;

  typedef struct packed {
    logic [15:0] numerator;
    logic [15:0] denominator;
    logic        reverse_thread;
    logic        closed_loop;
    logic [15:0] step_size;
    logic [30:0] length_limit;
  } ssg_cfg_t;

  typedef struct packed {
    kind_e                   kind;
    logic                    pin_a;
    logic                    pin_b;
    logic signed [DroW-1:0]  dro_position_um;
    logic                    at_index;
    logic                    stepper_busy;
  } ssg_in_t;

  typedef struct packed {
    kind_e                   kind;
    logic                    pin_a;
    logic                    pin_b;
    logic signed [PosW-1:0]  dro_q16;
    logic                    at_index;
    logic                    stepper_busy;
  } ssg_cv_t;

  typedef struct packed {
    logic                    step_pulse;
    logic                    direction_positive;
    logic [1:0]              mode;
    logic signed [PosW-1:0]  position;
    logic [1:0]              spin_dir;
  } ssg_res_t;

endpackage

>>> rtl/ssg_dro_conv.sv
// Pipeline that carries input beats and converts the DRO reading from
// micrometres to Q16.16 millimetres, rounded to nearest. Depends on ssg_pkg.
module ssg_dro_conv import ssg_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    valid_i,
  input  ssg_in_t item_i,
  output logic    valid_o,
  output ssg_cv_t item_o
);

  logic                   v1_q, v2_q, v3_q, v4_q, v5_q;
  ssg_in_t                it1_q, it2_q, it3_q, it4_q, it5_q;
  logic [DroW-1:0]        mag2_q, mag3_q;
  logic [16:0]            quo3_q, quo4_q;
  logic [6:0]             rem4_q;
  logic signed [PosW-1:0] dro5_q;

  logic [DroW-1:0]        mag_d;
  logic [47:0]            prod1;
  logic [DroW-1:0]        rem_full;
  logic [19:0]            frac_num;
  logic [40:0]            prod2;
  logic [29:0]            qmag;
  logic [PosW-1:0]        qext;
  logic signed [PosW-1:0] dro_d;

  always_comb begin
    mag_d    = it1_q.dro_position_um[DroW-1] ? DroW'(-it1_q.dro_position_um)
                                             : DroW'(it1_q.dro_position_um);
    prod1    = 48'(mag2_q) * 48'(DIV125_M1);
    rem_full = mag3_q - {quo3_q, 7'd0} + DroW'({quo3_q, 2'd0}) - DroW'(quo3_q);
    frac_num = {rem4_q, 13'd62};
    prod2    = 41'(frac_num) * 41'(DIV125_M2);
    qmag     = {quo4_q, prod2[39:27]};
    qext     = {2'b00, qmag};
    dro_d    = it4_q.dro_position_um[DroW-1] ? $signed(-qext) : $signed(qext);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      it1_q  <= item_i;
      it2_q  <= it1_q;
      mag2_q <= mag_d;
      it3_q  <= it2_q;
      mag3_q <= mag2_q;
      quo3_q <= prod1[46:30];
      it4_q  <= it3_q;
      quo4_q <= quo3_q;
      rem4_q <= rem_full[6:0];
      it5_q  <= it4_q;
      dro5_q <= dro_d;
    end
  end

  assign valid_o             = v5_q;
  assign item_o.kind         = it5_q.kind;
  assign item_o.pin_a        = it5_q.pin_a;
  assign item_o.pin_b        = it5_q.pin_b;
  assign item_o.dro_q16      = dro5_q;
  assign item_o.at_index     = it5_q.at_index;
  assign item_o.stepper_busy = it5_q.stepper_busy;

endmodule

>>> rtl/ssg_core.sv
// Configuration registers, run mode, ratio accumulator and carriage position; the state
// is updated once for each beat and the configuration on each write. Depends on ssg_pkg.
module ssg_core import ssg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                step_i,
  input  ssg_cv_t             item_i,
  output ssg_res_t            res_o
);

  ssg_cfg_t               cfg_q;
  run_state_e             run_q, run_d, key_run;
  logic [AccW-1:0]        acc_q, acc_d;
  logic                   pulse_q, pulse_d;
  logic signed [PosW-1:0] pos_q, pos_d;
  logic                   dirpos_q, dirpos_d;
  logic [1:0]             sdir_q, sdir_d;

  logic signed [PosW:0]   step_ext, pos_ext, step_sum, new_ext, lim_ext, neg_lim;
  logic signed [PosW-1:0] step_sat, new_pos;
  logic                   limit_hit, home;
  logic [AccW-1:0]        acc_sum, acc_sub;
  logic                   acc_hit;
  logic [1:0]             mode_enc;

  always_comb begin
    step_ext = $signed({17'd0, cfg_q.step_size});
    pos_ext  = {pos_q[PosW-1], pos_q};
    step_sum = dirpos_q ? pos_ext + step_ext : pos_ext - step_ext;
    if (step_sum[PosW] != step_sum[PosW-1]) begin
      step_sat = step_sum[PosW] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
    end else begin
      step_sat = step_sum[PosW-1:0];
    end
    new_pos   = cfg_q.closed_loop ? item_i.dro_q16 : step_sat;
    new_ext   = {new_pos[PosW-1], new_pos};
    lim_ext   = $signed({2'b00, cfg_q.length_limit});
    neg_lim   = -lim_ext;
    limit_hit = dirpos_q ? (new_ext >= lim_ext) : (new_ext <= neg_lim);
    home      = (pos_q >= -HOME_BAND) && (pos_q <= HOME_BAND);
    acc_sum   = acc_q + AccW'(cfg_q.numerator);
    acc_hit   = acc_sum >= AccW'(cfg_q.denominator);
    acc_sub   = acc_sum - AccW'(cfg_q.denominator);

    run_d    = run_q;
    acc_d    = acc_q;
    pulse_d  = pulse_q;
    pos_d    = pos_q;
    dirpos_d = dirpos_q;
    sdir_d   = sdir_q;
    key_run  = run_q;

    if (step_i) begin
      case (item_i.kind)
        KIND_EDGE: begin
          sdir_d = (item_i.pin_a == item_i.pin_b) ? SDIR_CW : SDIR_CCW;
          if (run_q == RUN_ACTIVE) begin
            if (pulse_q) begin
              pos_d = new_pos;
              if (limit_hit) begin
                run_d = RUN_LIMIT;
              end
            end
            pulse_d = acc_hit;
            acc_d   = acc_hit ? acc_sub : acc_sum;
          end
        end
        default: begin
          if (run_q == RUN_LIMIT) begin
            if (!item_i.stepper_busy && (item_i.kind != KIND_POLL || home)) begin
              run_d = RUN_IDLE;
            end
          end else begin
            if (item_i.kind == KIND_ARM && run_q == RUN_IDLE) begin
              key_run = RUN_PAUSED;
            end else if (item_i.kind == KIND_EXIT && run_q inside {RUN_PAUSED, RUN_ACTIVE}) begin
              key_run = RUN_IDLE;
            end
            run_d = key_run;
            if (key_run inside {RUN_PAUSED, RUN_ACTIVE}) begin
              if (sdir_q inside {SDIR_CW, SDIR_CCW}) begin
                if (!item_i.stepper_busy) begin
                  dirpos_d = cfg_q.reverse_thread;
                  if (key_run == RUN_PAUSED && item_i.at_index) begin
                    acc_d = '0;
                    run_d = RUN_ACTIVE;
                  end
                end
              end else if (key_run == RUN_ACTIVE) begin
                run_d = RUN_PAUSED;
              end
            end
          end
        end
      endcase
    end

    // A new ratio restarts the accumulator.
    if (cfg_we_i && (cfg_idx_i inside {CFG_NUMERATOR, CFG_DENOMINATOR})) begin
      acc_d = '0;
    end

    case (run_d)
      RUN_IDLE:   mode_enc = MODE_IDLE;
      RUN_PAUSED: mode_enc = MODE_PAUSED;
      RUN_ACTIVE: mode_enc = MODE_ACTIVE;
      RUN_LIMIT:  mode_enc = MODE_LIMIT;
      default:    mode_enc = MODE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.numerator      <= RST_NUMERATOR;
      cfg_q.denominator    <= RST_DENOMINATOR;
      cfg_q.reverse_thread <= 1'b0;
      cfg_q.closed_loop    <= 1'b0;
      cfg_q.step_size      <= RST_STEP_SIZE;
      cfg_q.length_limit   <= RST_LENGTH_LIMIT;
      run_q                <= RUN_IDLE;
      acc_q                <= '0;
      pulse_q              <= 1'b0;
      pos_q                <= '0;
      dirpos_q             <= 1'b0;
      sdir_q               <= SDIR_UNKNOWN;
    end else begin
      run_q    <= run_d;
      acc_q    <= acc_d;
      pulse_q  <= pulse_d;
      pos_q    <= pos_d;
      dirpos_q <= dirpos_d;
      sdir_q   <= sdir_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NUMERATOR:    cfg_q.numerator      <= cfg_data_i[15:0];
          CFG_DENOMINATOR:  cfg_q.denominator    <= cfg_data_i[15:0];
          CFG_REVERSE:      cfg_q.reverse_thread <= cfg_data_i[0];
          CFG_CLOSED_LOOP:  cfg_q.closed_loop    <= cfg_data_i[0];
          CFG_STEP_SIZE:    cfg_q.step_size      <= cfg_data_i[15:0];
          CFG_LENGTH_LIMIT: cfg_q.length_limit   <= cfg_data_i[30:0];
          default: ;
        endcase
      end
    end
  end

  assign res_o.step_pulse         = pulse_d;
  assign res_o.direction_positive = dirpos_d;
  assign res_o.mode               = mode_enc;
  assign res_o.position           = pos_d;
  assign res_o.spin_dir           = sdir_d;

endmodule

>>> rtl/ssg_out_buf.sv
// Result register with a skid stage, so that the pipeline keeps moving while
// a result beat waits. Depends on ssg_pkg.
module ssg_out_buf import ssg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  ssg_res_t res_i,
  input  logic     ready_i,
  output logic     valid_o,
  output ssg_res_t res_o,
  output logic     full_o
);

  logic     out_valid_q, skid_full_q;
  ssg_res_t out_q, skid_q;
  logic     pop;

  assign pop = out_valid_q && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (skid_full_q) begin
      if (pop) begin
        skid_full_q <= 1'b0;
      end
    end else if (push_i) begin
      if (out_valid_q && !pop) begin
        skid_full_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_full_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (out_valid_q && !pop) begin
        skid_q <= res_i;
      end else begin
        out_q <= res_i;
      end
    end
  end

  assign valid_o = out_valid_q;
  assign res_o   = out_q;
  assign full_o  = skid_full_q;

endmodule

>>> rtl/spindle_synced_step_generator_unit.sv
// Top level of the spindle-synchronised step generator.
// Depends on ssg_pkg, ssg_dro_conv, ssg_core and ssg_out_buf.
//
// The block takes one beat in every cycle while the skid stage is empty, and
// gives one result beat for each. A beat passes through the pipeline that
// converts the DRO reading into Q16.16 millimetres, then through the state
// update of the core, and its result is held in the result register. The
// state update loop closes through the core's state registers and allows one
// beat per cycle. Input is refused only while the skid stage behind the result
// register holds a beat. The user must write configuration only while no beat
// is in flight; the block itself does not enforce it.
module spindle_synced_step_generator_unit import ssg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // pin_a, pin_b, dro_position_um[23:0], at_index, stepper_busy, zero padding
  input  logic [InDataW-1:0]  s_axis_tdata,
  // kind
  input  logic [InUserW-1:0]  s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // step_pulse, direction_positive, mode[1:0], position[31:0],
  // spin_dir[1:0], zero padding
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  ssg_in_t  in_item;
  ssg_cv_t  cv_item;
  ssg_res_t core_res, out_res;
  logic     en, cv_valid, skid_full;

  assign en            = !skid_full;
  assign s_axis_tready = en;

  assign in_item.kind            = kind_e'(s_axis_tuser);
  assign in_item.pin_a           = s_axis_tdata[0];
  assign in_item.pin_b           = s_axis_tdata[1];
  assign in_item.dro_position_um = $signed(s_axis_tdata[25:2]);
  assign in_item.at_index        = s_axis_tdata[26];
  assign in_item.stepper_busy    = s_axis_tdata[27];

  ssg_dro_conv u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .item_i  (in_item),
    .valid_o (cv_valid),
    .item_o  (cv_item)
  );

  ssg_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (en && cv_valid),
    .item_i     (cv_item),
    .res_o      (core_res)
  );

  ssg_out_buf u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (en && cv_valid),
    .res_i   (core_res),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .res_o   (out_res),
    .full_o  (skid_full)
  );

  assign m_axis_tdata = {2'b00, out_res.spin_dir, out_res.position, out_res.mode,
                         out_res.direction_positive, out_res.step_pulse};

endmodule

>>> verif/ssg_result_checker.sv
// Result checker for the spindle-synchronised step generator: watches the input, result and
// configuration channels, predicts each result beat and compares it field by field.
// Depends on ssg_pkg for the codes, widths and reset values of the block.
module ssg_result_checker import ssg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  // pin_a, pin_b, dro_position_um[23:0], at_index, stepper_busy, zero padding
  input  logic [InDataW-1:0]  s_axis_tdata,
  // kind
  input  logic [InUserW-1:0]  s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // step_pulse, direction_positive, mode[1:0], position[31:0],
  // spin_dir[1:0], zero padding
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         errors_o,
  output int unsigned         outstanding_o
);

  logic [15:0]            ratio_num;
  logic [15:0]            ratio_den;
  logic                   rev_thread;
  logic                   closed_loop_en;
  logic [15:0]            step_q16;
  logic [30:0]            travel_limit;

  logic [1:0]             run_mode;
  logic [AccW-1:0]        ratio_acc;
  logic                   pulse_high;
  logic signed [PosW-1:0] carriage_q16;
  logic                   carriage_dir_pos;
  logic [1:0]             spindle_sense;

  ssg_res_t               carriage_results_q[$];

  task automatic reset_model();
    ratio_num        = RST_NUMERATOR;
    ratio_den        = RST_DENOMINATOR;
    rev_thread       = 1'b0;
    closed_loop_en   = 1'b0;
    step_q16         = RST_STEP_SIZE;
    travel_limit     = RST_LENGTH_LIMIT;
    run_mode         = MODE_IDLE;
    ratio_acc        = '0;
    pulse_high       = 1'b0;
    carriage_q16     = '0;
    carriage_dir_pos = 1'b0;
    spindle_sense    = SDIR_UNKNOWN;
  endtask

  function automatic logic signed [PosW-1:0] clamp_q16(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return PosW'(v);
  endfunction

  // Micrometres to Q16.16 millimetres, rounded to nearest with ties away from zero.
  function automatic logic signed [PosW-1:0] um_to_q16(logic signed [DroW-1:0] um);
    longint scaled;
    longint mag;
    longint quot;
    scaled = longint'(um) * 64'sd65536;
    mag    = (scaled < 0) ? -scaled : scaled;
    quot   = (mag + 64'sd500) / 64'sd1000;
    return PosW'((scaled < 0) ? -quot : quot);
  endfunction

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      CFG_NUMERATOR: begin
        ratio_num = data[15:0];
        ratio_acc = '0;
      end
      CFG_DENOMINATOR: begin
        ratio_den = data[15:0];
        ratio_acc = '0;
      end
      CFG_REVERSE:      rev_thread     = data[0];
      CFG_CLOSED_LOOP:  closed_loop_en = data[0];
      CFG_STEP_SIZE:    step_q16       = data[15:0];
      CFG_LENGTH_LIMIT: travel_limit   = data[30:0];
      default: ;
    endcase
  endtask

  task automatic predict_carriage_step(ssg_in_t beat);
    ssg_res_t res;
    longint   along;
    longint   mag;
    if (beat.kind == KIND_EDGE) begin
      spindle_sense = (beat.pin_a == beat.pin_b) ? SDIR_CW : SDIR_CCW;
      if (run_mode == MODE_ACTIVE) begin
        if (pulse_high) begin
          pulse_high = 1'b0;
          if (closed_loop_en) begin
            carriage_q16 = um_to_q16(beat.dro_position_um);
          end else if (carriage_dir_pos) begin
            carriage_q16 = clamp_q16(longint'(carriage_q16) + longint'(step_q16));
          end else begin
            carriage_q16 = clamp_q16(longint'(carriage_q16) - longint'(step_q16));
          end
          along = carriage_dir_pos ? longint'(carriage_q16) : -longint'(carriage_q16);
          if (along >= longint'(travel_limit)) run_mode = MODE_LIMIT;
        end
        ratio_acc = ratio_acc + {1'b0, ratio_num};
        if (ratio_acc >= {1'b0, ratio_den}) begin
          ratio_acc  = ratio_acc - {1'b0, ratio_den};
          pulse_high = 1'b1;
        end
      end
    end else if (run_mode == MODE_LIMIT) begin
      mag = (carriage_q16 < 0) ? -longint'(carriage_q16) : longint'(carriage_q16);
      if (!beat.stepper_busy && (beat.kind != KIND_POLL || mag <= longint'(HOME_BAND))) begin
        run_mode = MODE_IDLE;
      end
    end else begin
      if (beat.kind == KIND_ARM && run_mode == MODE_IDLE) begin
        run_mode = MODE_PAUSED;
      end else if (beat.kind == KIND_EXIT && run_mode != MODE_IDLE) begin
        run_mode = MODE_IDLE;
      end
      if (run_mode != MODE_IDLE) begin
        if (spindle_sense != SDIR_UNKNOWN) begin
          if (!beat.stepper_busy) begin
            carriage_dir_pos = rev_thread;
            if (run_mode == MODE_PAUSED && beat.at_index) begin
              ratio_acc = '0;
              run_mode  = MODE_ACTIVE;
            end
          end
        end else if (run_mode == MODE_ACTIVE) begin
          run_mode = MODE_PAUSED;
        end
      end
    end
    res.step_pulse         = pulse_high;
    res.direction_positive = carriage_dir_pos;
    res.mode               = run_mode;
    res.position           = carriage_q16;
    res.spin_dir           = spindle_sense;
    carriage_results_q.push_back(res);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors_o = errors_o + 1;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  initial begin
    errors_o      = 0;
    outstanding_o = 0;
    reset_model();
  end

  always @(posedge clk_i or negedge rst_ni) begin
    ssg_in_t  beat;
    ssg_res_t want;
    if (!rst_ni) begin
      reset_model();
      carriage_results_q.delete();
    end else begin
      if (cfg_we_i) write_register(cfg_idx_i, cfg_data_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (carriage_results_q.size() == 0) begin
          errors_o = errors_o + 1;
          $display("%0t: result beat with none expected, expected nothing actual %0h",
                   $time, m_axis_tdata);
        end else begin
          want = carriage_results_q.pop_front();
          check_field("step_pulse", 32'(want.step_pulse), 32'(m_axis_tdata[0]));
          check_field("direction_positive", 32'(want.direction_positive),
                      32'(m_axis_tdata[1]));
          check_field("mode", 32'(want.mode), 32'(m_axis_tdata[3:2]));
          check_field("position", want.position, m_axis_tdata[35:4]);
          check_field("spin_dir", 32'(want.spin_dir), 32'(m_axis_tdata[37:36]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        beat.kind            = kind_e'(s_axis_tuser);
        beat.pin_a           = s_axis_tdata[0];
        beat.pin_b           = s_axis_tdata[1];
        beat.dro_position_um = s_axis_tdata[25:2];
        beat.at_index        = s_axis_tdata[26];
        beat.stepper_busy    = s_axis_tdata[27];
        predict_carriage_step(beat);
      end
    end
    outstanding_o = carriage_results_q.size();
  end

endmodule

>>> verif/tb.sv
// Top of the step generator testbench: clock, reset, configuration writes and input beats,
// with bursty input and a stalling result receiver. Depends on ssg_pkg, the block's
// top level and ssg_result_checker, which does all prediction and comparison.
module tb;
  import ssg_pkg::*;

  localparam int unsigned CycleLimit  = 3_000_000;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned RandomPhases = 8;
  localparam int unsigned PhaseBeats   = 200;
  localparam int unsigned RunOutBeats  = 16;

  localparam logic [CfgIdxW-1:0]    CFG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0]    CFG_SPARE_HI = 3'd7;
  localparam logic signed [DroW-1:0] DRO_MAX     = 24'sh7F_FFFF;
  localparam logic signed [DroW-1:0] DRO_MIN     = 24'sh80_0000;
  localparam logic signed [DroW-1:0] DRO_ZERO    = 24'sh00_0000;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [InUserW-1:0]  s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  int unsigned check_errors;
  int unsigned results_outstanding;
  int unsigned cycle_count;

  ssg_in_t spindle_beats_q[$];

  spindle_synced_step_generator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  ssg_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .errors_o      (check_errors),
    .outstanding_o (results_outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // The receiver switches between always ready, coin-toss ready and short stall runs.
  initial begin
    int unsigned ready_style;
    int unsigned style_left;
    int unsigned stall_left;
    m_axis_tready = 1'b0;
    stall_left    = 0;
    forever begin
      ready_style = $urandom_range(0, 2);
      style_left  = $urandom_range(20, 200);
      repeat (style_left) begin
        @(negedge clk_i);
        case (ready_style)
          0: m_axis_tready = 1'b1;
          1: m_axis_tready = 1'($urandom_range(0, 1));
          default: begin
            if (stall_left != 0) begin
              m_axis_tready = 1'b0;
              stall_left    = stall_left - 1;
            end else begin
              m_axis_tready = 1'b1;
              stall_left    = $urandom_range(1, 6);
            end
          end
        endcase
      end
    end
  end

  task automatic queue_beat(kind_e kind, logic pin_a, logic pin_b,
                            logic signed [DroW-1:0] dro, logic at_index, logic busy);
    ssg_in_t beat;
    beat.kind            = kind;
    beat.pin_a           = pin_a;
    beat.pin_b           = pin_b;
    beat.dro_position_um = dro;
    beat.at_index        = at_index;
    beat.stepper_busy    = busy;
    spindle_beats_q.push_back(beat);
  endtask

  function automatic ssg_in_t random_beat();
    ssg_in_t     beat;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 68) beat.kind = KIND_EDGE;
    else if (pick < 76) beat.kind = KIND_ARM;
    else if (pick < 80) beat.kind = KIND_EXIT;
    else beat.kind = KIND_POLL;
    beat.pin_a = 1'($urandom_range(0, 1));
    beat.pin_b = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0:       beat.dro_position_um = DRO_MAX;
      1:       beat.dro_position_um = DRO_MIN;
      2, 3, 4: beat.dro_position_um = DroW'(int'($urandom_range(0, 40)) - 20);
      default: beat.dro_position_um = DroW'($urandom);
    endcase
    beat.at_index     = 1'($urandom_range(0, 1));
    beat.stepper_busy = ($urandom_range(0, 4) == 0);
    return beat;
  endfunction

  function automatic logic [15:0] pick_u16();
    case ($urandom_range(0, 9))
      0:       return 16'd1;
      1:       return 16'hFFFF;
      2:       return 16'd0;
      3, 4, 5: return 16'($urandom_range(1, 16));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  // Arrives in active mode from any mode, with the spindle direction known.
  task automatic go_active();
    queue_beat(KIND_EDGE, 1'b1, 1'b1, DRO_ZERO, 1'b0, 1'b0);
    queue_beat(KIND_ARM,  1'b0, 1'b0, DRO_ZERO, 1'b0, 1'b0);
    queue_beat(KIND_EXIT, 1'b0, 1'b0, DRO_ZERO, 1'b0, 1'b0);
    queue_beat(KIND_ARM,  1'b0, 1'b0, DRO_ZERO, 1'b0, 1'b0);
    queue_beat(KIND_POLL, 1'b0, 1'b0, DRO_ZERO, 1'b1, 1'b0);
  endtask

  task automatic stream_beats();
    ssg_in_t     beat;
    int unsigned burst_left;
    burst_left = 0;
    while (spindle_beats_q.size() != 0) begin
      if (burst_left == 0) begin
        s_axis_tvalid = 1'b0;
        if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 5)) @(negedge clk_i);
        burst_left = $urandom_range(1, 30);
      end
      beat          = spindle_beats_q.pop_front();
      s_axis_tuser  = beat.kind;
      s_axis_tdata  = {4'b0000, beat.stepper_busy, beat.at_index, beat.dro_position_um,
                       beat.pin_b, beat.pin_a};
      s_axis_tvalid = 1'b1;
      do @(posedge clk_i); while (!s_axis_tready);
      @(negedge clk_i);
      burst_left = burst_left - 1;
    end
    s_axis_tvalid = 1'b0;
  endtask

  task automatic settle();
    while (results_outstanding != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  initial begin
    int unsigned phase;
    logic [15:0] step_pick;
    logic [15:0] den_pick;
    logic [30:0] limit_pick;
    cycle_count   = 0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_EDGE;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_NUMERATOR;
    cfg_data_i    = '0;
    @(posedge rst_ni);
    @(negedge clk_i);

    // Reset settings: unknown spindle direction, busy stepper, index gating, pulse left high.
    queue_beat(KIND_POLL, 1'b0, 1'b0, DRO_ZERO, 1'b1, 1'b0);
    queue_beat(KIND_EXIT, 1'b0, 1'b0, DRO_ZERO, 1'b0, 1'b0);
    queue_beat(KIND_ARM,  1'b0, 1'b0, DRO_ZERO, 1'b0, 1'b0);
    queue_beat(KIND_POLL, 1'b0, 1'b0, DRO_ZERO, 1'b1, 1'b0);
    queue_beat(KIND_EDGE, 1'b0, 1'b0, DRO_ZERO, 1'b0, 1'b0);
    queue_beat(KIND_POLL, 1'b0, 1'b0, DRO_ZERO, 1'b1, 1'b1);
    queue_beat(KIND_POLL, 1'b0, 1'b0, DRO_ZERO, 1'b0, 1'b0);
    queue_beat(KIND_POLL, 1'b0, 1'b0, DRO_ZERO, 1'b1, 1'b0);
    queue_beat(KIND_EDGE, 1'b1, 1'b0, DRO_MAX,  1'b1, 1'b1);
    queue_beat(KIND_EDGE, 1'b0, 1'b1, DRO_MIN,  1'b0, 1'b1);
    queue_beat(KIND_ARM,  1'b1, 1'b1, DRO_MAX,  1'b1, 1'b0);
    queue_beat(KIND_EXIT, 1'b0, 1'b0, DRO_ZERO, 1'b0, 1'b0);
    queue_beat(KIND_ARM,  1'b0, 1'b0, DRO_ZERO, 1'b1, 1'b0);
    queue_beat(KIND_EDGE, 1'b1, 1'b1, DRO_ZERO, 1'b1, 1'b1);
    stream_beats();
    settle();

    // Zero limit in closed loop: limit on the first move, home-band poll, busy exits.
    write_reg(CFG_LENGTH_LIMIT, '0);
    write_reg(CFG_CLOSED_LOOP, 31'h7FFF_FFFF);
    write_reg(CFG_REVERSE, 31'd1);
    write_reg(CFG_NUMERATOR, 31'h7FFF_FFFF);
    write_reg(CFG_DENOMINATOR, 31'h0000_FFFF);
    write_reg(CFG_STEP_SIZE, 31'h7FFF_FFFF);
    write_reg(CFG_SPARE_LO, 31'h7FFF_FFFF);
    write_reg(CFG_SPARE_HI, 31'h0000_0000);
    queue_beat(KIND_EDGE, 1'b0, 1'b0, DRO_ZERO, 1'b0, 1'b0);
    queue_beat(KIND_POLL, 1'b0, 1'b0, DRO_ZERO, 1'b0, 1'b1);
    queue_beat(KIND_POLL, 1'b0, 1'b0, DRO_ZERO, 1'b0, 1'b0);
    queue_beat(KIND_ARM,  1'b0, 1'b0, DRO_ZERO, 1'b1, 1'b0);
    queue_beat(KIND_EDGE, 1'b1, 1'b0, DRO_MAX,  1'b0, 1'b0);
    queue_beat(KIND_POLL, 1'b0, 1'b0, DRO_ZERO, 1'b0, 1'b0);
    queue_beat(KIND_EXIT, 1'b0, 1'b0, DRO_ZERO, 1'b0, 1'b1);
    queue_beat(KIND_ARM,  1'b0, 1'b0, DRO_ZERO, 1'b0, 1'b0);
    stream_beats();
    settle();

    for (phase = 0; phase < RandomPhases; phase++) begin
      step_pick = pick_u16();
      den_pick  = (phase == 3) ? 16'd0 : pick_u16();
      case ($urandom_range(0, 5))
        0:       limit_pick = '0;
        1:       limit_pick = 31'h7FFF_FFFF;
        2:       limit_pick = 31'($urandom);
        default: limit_pick = 31'(step_pick * $urandom_range(1, 40));
      endcase
      write_reg(CFG_NUMERATOR, {15'($urandom), pick_u16()});
      write_reg(CFG_DENOMINATOR, {15'($urandom), den_pick});
      write_reg(CFG_REVERSE, CfgDataW'($urandom));
      write_reg(CFG_CLOSED_LOOP, CfgDataW'($urandom));
      write_reg(CFG_STEP_SIZE, {15'($urandom), step_pick});
      write_reg(CFG_LENGTH_LIMIT, limit_pick);
      write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_LO : CFG_SPARE_HI,
                CfgDataW'($urandom));
      go_active();
      repeat (PhaseBeats) spindle_beats_q.push_back(random_beat());
      stream_beats();
      settle();
    end

    // Open-loop steps from the far ends of the DRO range, first positive and then negative.
    for (phase = 0; phase < 2; phase++) begin
      write_reg(CFG_CLOSED_LOOP, 31'd1);
      write_reg(CFG_REVERSE, (phase == 0) ? 31'd1 : 31'd0);
      write_reg(CFG_NUMERATOR, 31'd1);
      write_reg(CFG_DENOMINATOR, 31'd1);
      write_reg(CFG_STEP_SIZE, 31'h0000_FFFF);
      write_reg(CFG_LENGTH_LIMIT, 31'h7FFF_FFFF);
      go_active();
      repeat (2) queue_beat(KIND_EDGE, 1'b0, 1'b1, (phase == 0) ? DRO_MAX : DRO_MIN,
                            1'b0, 1'b0);
      stream_beats();
      settle();
      write_reg(CFG_CLOSED_LOOP, 31'd0);
      repeat (RunOutBeats) begin
        queue_beat(KIND_EDGE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   DroW'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      stream_beats();
      settle();
    end

    if (check_errors == 0 && results_outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
